@@ src/micdb_pkg.sv @@
// micdb_pkg: shared types and constants of the multichannel integrating debouncer.
// No dependencies; used by micdb_chan and multichannel_integrating_debouncer.
`default_nettype none

package micdb_pkg;

  // fixed channel roles
  localparam int unsigned EMERGENCY_CH = 0;
  localparam int unsigned RESET_CH     = 1;
  localparam int unsigned HEAT_CH      = 10;

  // threshold field layout inside the two group registers
  localparam int unsigned FIELD_STRIDE = 3;
  localparam int unsigned GROUP_SIZE   = 12;

  // field widths
  localparam int unsigned LEVEL_W  = 24;
  localparam int unsigned GROUP_W  = 36;
  localparam int unsigned FLAG_W   = 3;
  localparam int unsigned TDATA_W  = 32;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned REG_IDX_W = 2;

  // event flag bits
  localparam int unsigned FLAG_EMERGENCY = 0;
  localparam int unsigned FLAG_RESET     = 1;
  localparam int unsigned FLAG_HEAT      = 2;

  // register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_MASK = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_THR_LOW     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THR_HIGH    = 2'd2;

  // register reset values
  localparam logic [LEVEL_W-1:0] MASK_RESET   = 24'h000801;
  localparam logic [GROUP_W-1:0] THR_LO_RESET = 36'd48782452074;
  localparam logic [GROUP_W-1:0] THR_HI_RESET = 36'd48632257365;

  // per-channel status from one update
  typedef struct packed {
    logic deb;      // next qualified level
    logic rise;     // qualified level goes 0 -> 1 this tick
    logic sat_act;  // active tick with counter at or above threshold
  } chan_res_t;

endpackage

`default_nettype wire

@@ src/multichannel_integrating_debouncer.sv @@
// multichannel_integrating_debouncer: top level, stream in/out plus APB configuration.
// Depends on micdb_pkg and micdb_chan.
`default_nettype none

// Each input transaction is one scan tick of up to 24 raw pin levels plus a 3-bit
// event clear mask; each tick yields exactly one output transaction carrying the
// debounced levels and the three sticky event flags (emergency, reset, heat) as
// they stand after that tick. Every channel runs an up/down integrator against
// its own 3-bit threshold and polarity. One transaction per clock: all channel
// updates are independent single-cycle logic feeding the state registers, which
// also serve as the output register, so in_tready stays high as long as the
// output is empty or being taken in the same cycle. out_tvalid is set in the
// cycle after input acceptance. Configuration (active_high_mask at 0x00,
// thresholds_low_group at 0x08, thresholds_high_group at 0x10) must be written via
// APB while the stream is idle, not enforced by the block; pready is always high.

module multichannel_integrating_debouncer import micdb_pkg::*; #(
  parameter int unsigned CHANNELS   = 24,
  parameter int unsigned COUNT_BITS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // in_tdata: [23:0] raw_levels, [26:24] event_clear, [31:27] zero
  input  wire logic [TDATA_W-1:0] in_tdata,
  input  wire logic               in_tvalid,
  output      logic               in_tready,
  // out_tdata: [23:0] qualified_levels, [24] emergency flag, [25] reset flag,
  //            [26] heat flag, [31:27] zero
  output      logic [TDATA_W-1:0] out_tdata,
  output      logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [CFG_AW-1:0]  cfg_paddr,
  input  wire logic [CFG_DW-1:0]  cfg_pwdata,
  output      logic [CFG_DW-1:0]  cfg_prdata,
  output      logic               cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0]   mask_r;
  logic [GROUP_W-1:0]   thr_lo_r;
  logic [GROUP_W-1:0]   thr_hi_r;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= MASK_RESET;
      thr_lo_r <= THR_LO_RESET;
      thr_hi_r <= THR_HI_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACTIVE_MASK: mask_r   <= cfg_pwdata[LEVEL_W-1:0];
        REG_THR_LOW:     thr_lo_r <= cfg_pwdata[GROUP_W-1:0];
        REG_THR_HIGH:    thr_hi_r <= cfg_pwdata[GROUP_W-1:0];
        default: ;       // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACTIVE_MASK: cfg_prdata = CFG_DW'(mask_r);
      REG_THR_LOW:     cfg_prdata = CFG_DW'(thr_lo_r);
      REG_THR_HIGH:    cfg_prdata = CFG_DW'(thr_hi_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stream handshake: state registers double as the output register
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Channel update
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0]    raw;
  logic [FLAG_W-1:0]     clr;
  logic [COUNT_BITS-1:0] cnt_r   [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_nxt [CHANNELS];
  logic [CHANNELS-1:0]   deb_r;
  logic [CHANNELS-1:0]   deb_nxt;
  chan_res_t             res     [CHANNELS];
  logic [FLAG_W-1:0]     flags_r;
  logic [FLAG_W-1:0]     flags_kept;
  logic [FLAG_W-1:0]     flags_nxt;
  logic                  reset_hit;
  logic                  heat_hit;

  assign raw = in_tdata[LEVEL_W-1:0];
  assign clr = in_tdata[LEVEL_W +: FLAG_W];

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    logic [COUNT_BITS-1:0] thr;

    // threshold field, masked to the counter width
    if (ch < GROUP_SIZE) begin : g_lo
      assign thr = thr_lo_r[FIELD_STRIDE*ch +: COUNT_BITS];
    end else begin : g_hi
      assign thr = thr_hi_r[FIELD_STRIDE*(ch-GROUP_SIZE) +: COUNT_BITS];
    end

    micdb_chan #(
      .COUNT_BITS (COUNT_BITS)
    ) u_chan (
      .level    (raw[ch]),
      .act_high (mask_r[ch]),
      .cnt      (cnt_r[ch]),
      .thr      (thr),
      .deb      (deb_r[ch]),
      .cnt_nxt  (cnt_nxt[ch]),
      .res      (res[ch])
    );

    assign deb_nxt[ch] = res[ch].deb;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[ch] <= '0;
      end else if (in_acc) begin
        cnt_r[ch] <= cnt_nxt[ch];
      end
    end
  end

  // Events for channels that do not exist never fire.
  if (CHANNELS > RESET_CH) begin : g_rst_ev
    assign reset_hit = res[RESET_CH].sat_act;
  end else begin : g_no_rst_ev
    assign reset_hit = 1'b0;
  end

  if (CHANNELS > HEAT_CH) begin : g_heat_ev
    assign heat_hit = res[HEAT_CH].rise;
  end else begin : g_no_heat_ev
    assign heat_hit = 1'b0;
  end

  // Clear first, then set; the emergency edge of this tick already counts
  // for the reset-while-emergency check.
  always_comb begin
    flags_kept = flags_r & ~clr;
    flags_nxt  = flags_kept;
    flags_nxt[FLAG_EMERGENCY] = flags_kept[FLAG_EMERGENCY] || res[EMERGENCY_CH].rise;
    flags_nxt[FLAG_RESET]     = flags_kept[FLAG_RESET]
                                || (reset_hit && flags_nxt[FLAG_EMERGENCY]);
    flags_nxt[FLAG_HEAT]      = flags_kept[FLAG_HEAT] || heat_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r   <= '0;
      flags_r <= '0;
    end else if (in_acc) begin
      deb_r   <= deb_nxt;
      flags_r <= flags_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output packing
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] qual;

  always_comb begin
    qual                 = '0;
    qual[CHANNELS-1:0]   = deb_r;
  end

  always_comb begin
    out_tdata                    = '0;
    out_tdata[LEVEL_W-1:0]       = qual;
    out_tdata[LEVEL_W +: FLAG_W] = flags_r;
  end

endmodule

`default_nettype wire

@@ src/micdb_chan.sv @@
// micdb_chan: one channel of the integrating debouncer (counter and qualified level update).
// Depends on micdb_pkg.
`default_nettype none

module micdb_chan import micdb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 3
) (
  input  wire logic                  level,
  input  wire logic                  act_high,
  input  wire logic [COUNT_BITS-1:0] cnt,
  input  wire logic [COUNT_BITS-1:0] thr,
  input  wire logic                  deb,
  output      logic [COUNT_BITS-1:0] cnt_nxt,
  output      chan_res_t             res
);

  logic active;
  logic sat;

  assign active = (level == act_high);
  assign sat    = (cnt >= thr);

  always_comb begin
    cnt_nxt = cnt;
    res     = '0;
    res.deb = deb;
    if (active) begin
      if (!sat) begin
        cnt_nxt = cnt + COUNT_BITS'(1);
      end else begin
        res.deb     = 1'b1;
        res.rise    = !deb;
        res.sat_act = 1'b1;
      end
    end else begin
      if (cnt != '0) begin
        cnt_nxt = cnt - COUNT_BITS'(1);
      end else begin
        res.deb = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/multichannel_integrating_debouncer_tb.sv @@
// multichannel_integrating_debouncer_tb: self-checking stream testbench for the debouncer.
// Depends on micdb_pkg and multichannel_integrating_debouncer; a scan-tick predictor
// inside the bench computes the expected levels and sticky flags of every transaction.
`default_nettype none

module multichannel_integrating_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import micdb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TICKS_PER_PHASE = 110;

  // Under the reset polarity, channels 0 and 11 are active-high and all others
  // active-low, so these two raw patterns make every channel active or idle.
  localparam logic [LEVEL_W-1:0] ALL_ACT  = MASK_RESET;
  localparam logic [LEVEL_W-1:0] ALL_IDLE = ~MASK_RESET;

  // one output transaction, laid out as out_tdata[26:0]
  typedef struct packed {
    logic               heat_ev;
    logic               reset_ev;
    logic               emerg_ev;
    logic [LEVEL_W-1:0] levels;
  } scan_result_t;

  // directed scan tick; pinned rows carry their expected result inline
  typedef struct {
    logic [LEVEL_W-1:0] raw;
    logic [FLAG_W-1:0]  clr;
    bit                 pinned;
    scan_result_t       res;
  } scan_row_t;

  logic               clk;
  logic               rst_n;
  logic [TDATA_W-1:0] in_tdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [CFG_DW-1:0]  cfg_pwdata;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  // predictor state: a private copy of the block's registers and counters
  logic [LEVEL_W-1:0] cfg_polarity;
  logic [GROUP_W-1:0] cfg_thr_lo;
  logic [GROUP_W-1:0] cfg_thr_hi;
  logic [2:0]         lane_counts [LEVEL_W];
  logic [LEVEL_W-1:0] held_levels;
  logic [FLAG_W-1:0]  sticky_flags;

  scan_result_t       results_due [$];
  scan_result_t       pinned_res;
  bit                 pinned_valid;
  int unsigned        ticks_taken;
  int unsigned        results_seen;
  int unsigned        err_cnt;
  int unsigned        cycle_cnt;
  logic [CFG_DW-1:0]  cfg_rd_capture;

  // Directed opening: reset config. Walks every channel through rise, hold and
  // drain, hitting the emergency edge, reset-while-emergency and heat edge,
  // and the all-zero / all-one raw extremes.
  scan_row_t scan_rows [21] = '{
    '{ALL_IDLE,     3'b111, 1'b1, '0},  // fresh after reset: nothing qualified
    '{ALL_ACT,      3'b000, 1'b0, '0},
    '{ALL_ACT,      3'b000, 1'b0, '0},
    '{ALL_ACT,      3'b000, 1'b0, '0},  // ch0 (thr 2) qualifies: emergency edge
    '{ALL_ACT,      3'b000, 1'b0, '0},
    '{ALL_ACT,      3'b000, 1'b0, '0},
    '{ALL_ACT,      3'b000, 1'b0, '0},  // thr-5 channels: reset and heat flags
    '{ALL_ACT,      3'b000, 1'b0, '0},  // saturated hold
    '{ALL_ACT,      3'b101, 1'b0, '0},  // clear emergency/heat, no fresh edge
    '{ALL_ACT,      3'b010, 1'b0, '0},  // clear reset; emergency gone, stays 0
    '{24'h000000,   3'b000, 1'b0, '0},
    '{24'hFFFFFF,   3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b000, 1'b0, '0},
    '{ALL_IDLE,     3'b111, 1'b1, '0},  // fully drained and flags cleared
    '{ALL_ACT,      3'b000, 1'b0, '0}
  };

  multichannel_integrating_debouncer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: one scan tick. Clears go first, then channels in ascending order
  // so an emergency edge in this tick already counts for the reset channel.
  // ---------------------------------------------------------------------------
  task automatic integrate_scan(input logic [LEVEL_W-1:0] raw, input logic [FLAG_W-1:0] clr,
                                output scan_result_t res);
    logic [2:0] cnt;
    logic [2:0] thr;
    logic       active;
    sticky_flags = sticky_flags & ~clr;
    for (int ch = 0; ch < LEVEL_W; ch++) begin
      active = (raw[ch] == cfg_polarity[ch]);
      cnt    = lane_counts[ch];
      thr    = (ch < GROUP_SIZE) ? cfg_thr_lo[ch*FIELD_STRIDE +: 3]
                                 : cfg_thr_hi[(ch-GROUP_SIZE)*FIELD_STRIDE +: 3];
      if (active) begin
        // a count left above a lowered threshold counts as saturated
        if (cnt < thr) begin
          cnt = cnt + 3'd1;
        end else begin
          if (!held_levels[ch]) begin
            held_levels[ch] = 1'b1;
            if (ch == EMERGENCY_CH) sticky_flags[FLAG_EMERGENCY] = 1'b1;
            if (ch == HEAT_CH) sticky_flags[FLAG_HEAT] = 1'b1;
          end
          if (ch == RESET_CH && sticky_flags[FLAG_EMERGENCY]) sticky_flags[FLAG_RESET] = 1'b1;
        end
      end else if (cnt != 3'd0) begin
        cnt = cnt - 3'd1;
      end else begin
        held_levels[ch] = 1'b0;
      end
      lane_counts[ch] = cnt;
    end
    res.levels   = held_levels;
    res.emerg_ev = sticky_flags[FLAG_EMERGENCY];
    res.reset_ev = sticky_flags[FLAG_RESET];
    res.heat_ev  = sticky_flags[FLAG_HEAT];
  endtask

  task automatic report_mismatch(input string what, input logic [CFG_DW-1:0] got,
                                 input logic [CFG_DW-1:0] want);
    $display("mismatch: %s (result %0d) got %0h want %0h", what, results_seen, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: all handshakes sampled at the rising edge, before the DUT's
  // registers update. Outputs are checked before the same-edge input is
  // predicted, so the queue order always matches the stream order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    scan_result_t pred;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[FLAG_W+LEVEL_W-1:0];
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected", CFG_DW'(got), '0);
        end else begin
          want = results_due.pop_front();
          if (got.levels !== want.levels)
            report_mismatch("qualified_levels", CFG_DW'(got.levels), CFG_DW'(want.levels));
          if (got.emerg_ev !== want.emerg_ev)
            report_mismatch("emergency flag", CFG_DW'(got.emerg_ev), CFG_DW'(want.emerg_ev));
          if (got.reset_ev !== want.reset_ev)
            report_mismatch("reset flag", CFG_DW'(got.reset_ev), CFG_DW'(want.reset_ev));
          if (got.heat_ev !== want.heat_ev)
            report_mismatch("heat flag", CFG_DW'(got.heat_ev), CFG_DW'(want.heat_ev));
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        // the predictor always runs so its state tracks the block
        integrate_scan(in_tdata[LEVEL_W-1:0], in_tdata[LEVEL_W +: FLAG_W], pred);
        results_due.push_back(pinned_valid ? pinned_res : pred);
        ticks_taken++;
      end
      if (cfg_psel && cfg_penable && !cfg_pwrite && cfg_pready) cfg_rd_capture = cfg_prdata;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: cycles through stall styles (always ready, coin flip, mostly
  // stalled, alternating) so back-pressure lands on every phase.
  initial begin
    int unsigned mode;
    int unsigned left;
    bit          toggle;
    mode   = 0;
    left   = 0;
    toggle = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(5, 60);
      end
      left--;
      toggle = ~toggle;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(1));
        2: out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= toggle;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender-side tasks; each is entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [LEVEL_W-1:0] raw, input logic [FLAG_W-1:0] clr);
    int unsigned n0;
    n0 = ticks_taken;
    in_tdata  <= {{(TDATA_W-LEVEL_W-FLAG_W){1'b0}}, clr, raw};
    in_tvalid <= 1'b1;
    do @(negedge clk); while (ticks_taken == n0);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
    // every tick yields a result: a short settle is plenty
    repeat (2) @(negedge clk);
  endtask

  // APB write followed by a readback of the same register
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    logic [CFG_DW-1:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_ACTIVE_MASK: begin
        cfg_polarity = val[LEVEL_W-1:0];
        want = CFG_DW'(cfg_polarity);
      end
      REG_THR_LOW: begin
        cfg_thr_lo = val[GROUP_W-1:0];
        want = CFG_DW'(cfg_thr_lo);
      end
      default: begin
        cfg_thr_hi = val[GROUP_W-1:0];
        want = CFG_DW'(cfg_thr_hi);
      end
    endcase
    if ((cfg_rd_capture & ((64'd1 << GROUP_W) - 1)) !== want)
      report_mismatch("register readback", cfg_rd_capture, want);
  endtask

  // Random scan ticks. Mostly slowly changing levels, so counters actually
  // climb to threshold and drain again; the rest is per-tick noise. Sender
  // works in bursts, with gaps and one full hold-off until the queue empties.
  task automatic run_random(input int unsigned n_ticks);
    logic [LEVEL_W-1:0] levels;
    logic [FLAG_W-1:0]  clr;
    int unsigned        burst;
    int unsigned        flip_div;
    int unsigned        gap;
    levels = LEVEL_W'($urandom);
    burst  = 0;
    flip_div = 4;
    for (int unsigned k = 0; k < n_ticks; k++) begin
      if (burst == 0) begin
        burst    = $urandom_range(1, 40);
        flip_div = 1 << $urandom_range(1, 5);
        gap      = $urandom_range(0, 6);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst--;
      if (k == n_ticks / 2) drain_results();
      if ($urandom_range(9) == 0) begin
        levels = LEVEL_W'($urandom);
      end else begin
        for (int ch = 0; ch < LEVEL_W; ch++)
          if ($urandom_range(flip_div - 1) == 0) levels[ch] = ~levels[ch];
      end
      clr = ($urandom_range(5) == 0) ? FLAG_W'($urandom) : '0;
      send_tick(levels, clr);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tvalid    = 1'b0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    pinned_valid = 1'b0;
    pinned_res   = '0;
    ticks_taken  = 0;
    results_seen = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    cfg_rd_capture = '0;
    cfg_polarity = MASK_RESET;
    cfg_thr_lo   = THR_LO_RESET;
    cfg_thr_hi   = THR_HI_RESET;
    held_levels  = '0;
    sticky_flags = '0;
    foreach (lane_counts[i]) lane_counts[i] = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (scan_rows[r]) begin
      pinned_valid = scan_rows[r].pinned;
      pinned_res   = scan_rows[r].res;
      send_tick(scan_rows[r].raw, scan_rows[r].clr);
      pinned_valid = 1'b0;
    end

    // extremes: everything active-low with zero thresholds (instant qualify)
    drain_results();
    cfg_write(REG_ACTIVE_MASK, '0);
    cfg_write(REG_THR_LOW, '0);
    cfg_write(REG_THR_HIGH, '0);
    run_random(TICKS_PER_PHASE);

    // everything active-high with the largest threshold
    drain_results();
    cfg_write(REG_ACTIVE_MASK, {CFG_DW{1'b1}});
    cfg_write(REG_THR_LOW, {CFG_DW{1'b1}});
    cfg_write(REG_THR_HIGH, {CFG_DW{1'b1}});
    run_random(TICKS_PER_PHASE);

    // drop thresholds under the counts just built up
    drain_results();
    cfg_write(REG_THR_LOW, '0);
    cfg_write(REG_THR_HIGH, {$urandom, $urandom});
    run_random(TICKS_PER_PHASE);

    // random settings, upper pwdata bits included to check field masking
    repeat (5) begin
      drain_results();
      cfg_write(REG_ACTIVE_MASK, {$urandom, $urandom});
      cfg_write(REG_THR_LOW, {$urandom, $urandom});
      cfg_write(REG_THR_HIGH, {$urandom, $urandom});
      run_random(TICKS_PER_PHASE);
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
